[design/assert_macros.svh]
// assertion macros for the checker file lavm_checker.sv
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while reset is released
`define LAVM_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// checked on every edge, reset included
`define LAVM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/lavm_pkg.sv]
// shared types and constants of the look-at view matrix block
// no dependencies
package lavm_pkg;

    // register index decoded from paddr
    localparam logic REG_NEAR_EPS = 1'b0;

    // rsqrt constants, q30
    localparam logic [30:0] Q30_ONE    = 31'h4000_0000;
    localparam logic [31:0] THREE_Q30  = 32'hC000_0000;
    localparam logic [30:0] GUESS_LOW  = 31'd903016874;
    localparam logic [30:0] GUESS_HIGH = 31'd638876385;

    // one camera setup after classification
    typedef struct packed {
        logic [31:0] eye_x;
        logic [31:0] eye_y;
        logic [31:0] eye_z;
        logic [31:0] up_x;
        logic [31:0] up_y;
        logic [31:0] up_z;
        logic [32:0] d_x;
        logic [32:0] d_y;
        logic [32:0] d_z;
        logic        near;
    } item_t;

    // one matrix row on the result side
    typedef struct packed {
        logic [1:0]  row_index;
        logic [31:0] col0;
        logic [31:0] col1;
        logic [31:0] col2;
        logic [31:0] col3;
        logic        last_row;
    } row_t;

endpackage

[design/lavm_front.sv]
// front end: accepts a camera setup, forms eye - center and the near test
// depends on lavm_pkg
module lavm_front import lavm_pkg::*; (
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] eye_x,
    input  logic [31:0] eye_y,
    input  logic [31:0] eye_z,
    input  logic [31:0] center_x,
    input  logic [31:0] center_y,
    input  logic [31:0] center_z,
    input  logic [31:0] up_x,
    input  logic [31:0] up_y,
    input  logic [31:0] up_z,
    input  logic [15:0] near_eps,
    input  logic        q_full,
    output logic        q_wr,
    output item_t       q_item
);

    logic signed [32:0] d_x, d_y, d_z;
    logic signed [32:0] eps_pos, eps_neg;
    logic               near_x, near_y, near_z;

    assign d_x = $signed({eye_x[31], eye_x}) - $signed({center_x[31], center_x});
    assign d_y = $signed({eye_y[31], eye_y}) - $signed({center_y[31], center_y});
    assign d_z = $signed({eye_z[31], eye_z}) - $signed({center_z[31], center_z});

    assign eps_pos = $signed({17'd0, near_eps});
    assign eps_neg = -eps_pos;

    // |d| < eps written as two compares
    assign near_x = (d_x < eps_pos) && (d_x > eps_neg);
    assign near_y = (d_y < eps_pos) && (d_y > eps_neg);
    assign near_z = (d_z < eps_pos) && (d_z > eps_neg);

    assign s_ready = !q_full;
    assign q_wr    = s_valid && !q_full;

    always_comb begin
        q_item.eye_x = eye_x;
        q_item.eye_y = eye_y;
        q_item.eye_z = eye_z;
        q_item.up_x  = up_x;
        q_item.up_y  = up_y;
        q_item.up_z  = up_z;
        q_item.d_x   = d_x;
        q_item.d_y   = d_y;
        q_item.d_z   = d_z;
        q_item.near  = near_x && near_y && near_z;
    end

endmodule

[design/lavm_queue.sv]
// two-entry queue between the front end and the matrix engine
// depends on lavm_pkg
module lavm_queue import lavm_pkg::*; (
    input  logic  clk,
    input  logic  rstn,
    input  logic  wr_en,
    input  item_t wr_item,
    output logic  full,
    input  logic  rd_en,
    output logic  rd_valid,
    output item_t rd_item
);

    item_t      mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;

    assign full     = (count_reg == 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_item  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem_reg[wr_ptr_reg] <= wr_item;
        end
        if (!rstn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (wr_en) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (rd_en && rd_valid) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            unique case ({wr_en, rd_en && rd_valid})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

[design/lavm_engine.sv]
// matrix engine: three normalizations, two cross products and the
// translation row on one shared 33x33 multiplier, then four row words
// depends on lavm_pkg
module lavm_engine import lavm_pkg::*; #(
    parameter int FRAC_BITS   = 16,
    parameter int RSQRT_ITERS = 4
) (
    input  logic  clk,
    input  logic  rstn,
    input  logic  q_valid,
    input  item_t q_item,
    output logic  q_ready,
    output logic  m_valid,
    input  logic  m_ready,
    output row_t  m_row
);

    localparam int IT_W = $clog2(RSQRT_ITERS);
    localparam logic [31:0] ONE_Q = 32'd1 << FRAC_BITS;
    localparam logic signed [63:0] HALF_Q = 64'sd1 <<< (FRAC_BITS - 1);
    localparam logic [5:0] RS_BASE = 6'(60 - FRAC_BITS);
    localparam logic [1:0] AX_F = 2'd0;
    localparam logic [1:0] AX_S = 2'd1;
    localparam logic [1:0] AX_V = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE, ST_MAG, ST_SHIFT, ST_SQ, ST_NORM,
        ST_NEWT, ST_UNIT, ST_CROSS, ST_TRANS, ST_EMIT
    } state_t;

    // cross(a, b) product order: a1*b2, a2*b1, a2*b0, a0*b2, a0*b1, a1*b0
    function automatic logic [1:0] cross_a(input logic [2:0] n);
        logic [1:0] r;
        unique case (n)
            3'd0, 3'd5: r = 2'd1;
            3'd1, 3'd2: r = 2'd2;
            default:    r = 2'd0;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] cross_b(input logic [2:0] n);
        logic [1:0] r;
        unique case (n)
            3'd0, 3'd3: r = 2'd2;
            3'd1, 3'd4: r = 2'd1;
            default:    r = 2'd0;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] tr_lane(input logic [3:0] n);
        logic [1:0] r;
        unique case (n)
            4'd0, 4'd3, 4'd6: r = 2'd0;
            4'd1, 4'd4, 4'd7: r = 2'd1;
            default:          r = 2'd2;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] tr_axis(input logic [3:0] n);
        logic [1:0] r;
        if (n < 4'd3) begin
            r = 2'd0;
        end else if (n < 4'd6) begin
            r = 2'd1;
        end else begin
            r = 2'd2;
        end
        return r;
    endfunction

    state_t                    state_reg;
    logic [3:0]                cnt_reg;
    logic [IT_W-1:0]           it_reg;
    logic [1:0]                axis_reg;
    logic [1:0]                row_reg;
    logic                      near_reg;
    logic signed [31:0]        eye_reg [3];
    logic signed [31:0]        up_reg  [3];
    logic signed [31:0]        f_reg   [3];
    logic signed [31:0]        s_reg   [3];
    logic signed [31:0]        v_reg   [3];
    logic signed [31:0]        tr_reg  [3];
    logic signed [63:0]        vec_reg [3];
    logic [61:0]               mag_reg [3];
    logic [61:0]               s2_reg;
    logic [4:0]                k_reg;
    logic [30:0]               y_reg;
    logic [31:0]               corr_reg;
    logic signed [63:0]        acc_reg;
    logic signed [65:0]        prod_reg;
    logic                      m_valid_reg;
    row_t                      out_reg;

    logic signed [32:0] opa, opb;
    logic [3:0]         cm1;
    logic signed [31:0] ca [3];
    logic signed [31:0] cb [3];
    logic signed [31:0] ta [3];
    logic signed [63:0] p64;
    logic [5:0]         rs;
    logic [63:0]        rnd, r_next;
    logic signed [31:0] u_next;
    logic [31:0]        t_mid;
    logic [30:0]        y_raw;
    logic signed [63:0] tacc_next, tsh;
    logic signed [31:0] tsat;
    logic               big, mid;
    row_t               row_next;

    assign q_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_row   = out_reg;
    assign cm1     = cnt_reg - 4'd1;
    assign p64     = prod_reg[63:0];

    // cross operands: (up, f) for the side axis, (f, s) for the up axis
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            ca[i] = (axis_reg == AX_S) ? up_reg[i] : f_reg[i];
            cb[i] = (axis_reg == AX_S) ? f_reg[i] : s_reg[i];
        end
    end

    // translation axis for the current product
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            unique case (tr_axis(cnt_reg))
                2'd0:    ta[i] = s_reg[i];
                2'd1:    ta[i] = v_reg[i];
                default: ta[i] = f_reg[i];
            endcase
        end
    end

    // multiplier operand select
    always_comb begin
        opa = '0;
        opb = '0;
        unique case (state_reg)
            ST_SQ: begin
                if (cnt_reg < 4'd3) begin
                    opa = $signed({3'd0, mag_reg[cnt_reg[1:0]][29:0]});
                    opb = opa;
                end
            end
            ST_NEWT: begin
                unique case (cnt_reg)
                    4'd0: begin
                        opa = $signed({2'd0, y_reg});
                        opb = $signed({2'd0, y_reg});
                    end
                    4'd1: begin
                        opa = $signed({1'b0, s2_reg[61:30]});
                        opb = $signed({1'b0, prod_reg[61:30]});
                    end
                    4'd3: begin
                        opa = $signed({2'd0, y_reg});
                        opb = $signed({1'b0, corr_reg});
                    end
                    default: begin
                        opa = '0;
                        opb = '0;
                    end
                endcase
            end
            ST_UNIT: begin
                if (cnt_reg < 4'd3) begin
                    opa = $signed({3'd0, mag_reg[cnt_reg[1:0]][29:0]});
                    opb = $signed({2'd0, y_reg});
                end
            end
            ST_CROSS: begin
                if (cnt_reg < 4'd6) begin
                    opa = $signed({ca[cross_a(cnt_reg[2:0])][31], ca[cross_a(cnt_reg[2:0])]});
                    opb = $signed({cb[cross_b(cnt_reg[2:0])][31], cb[cross_b(cnt_reg[2:0])]});
                end
            end
            ST_TRANS: begin
                if (cnt_reg < 4'd9) begin
                    opa = $signed({ta[tr_lane(cnt_reg)][31], ta[tr_lane(cnt_reg)]});
                    opb = $signed({eye_reg[tr_lane(cnt_reg)][31], eye_reg[tr_lane(cnt_reg)]});
                end
            end
            default: begin
                opa = '0;
                opb = '0;
            end
        endcase
    end

    // newton step pieces
    assign t_mid = prod_reg[61:30];
    assign y_raw = prod_reg[61:31];

    // unit component: round to nearest, ties away from zero
    assign rs     = RS_BASE - {1'b0, k_reg};
    assign rnd    = 64'd1 << (rs - 6'd1);
    assign r_next = ({3'd0, prod_reg[60:0]} + rnd) >> rs;
    assign u_next = vec_reg[cm1[1:0]][63] ? -$signed(r_next[31:0]) : $signed(r_next[31:0]);

    // translation: accumulate half - sum, floor shift, saturate
    assign tacc_next = ((tr_lane(cm1) == 2'd0) ? HALF_Q : acc_reg) - p64;
    assign tsh       = tacc_next >>> FRAC_BITS;
    always_comb begin
        if (tsh > 64'sd2147483647) begin
            tsat = 32'sh7FFF_FFFF;
        end else if (tsh < -64'sd2147483648) begin
            tsat = 32'sh8000_0000;
        end else begin
            tsat = tsh[31:0];
        end
    end

    always_comb begin
        big = 1'b0;
        mid = 1'b0;
        for (int i = 0; i < 3; i++) begin
            big = big | (|mag_reg[i][61:38]);
            mid = mid | (|mag_reg[i][37:30]);
        end
    end

    // row being handed to the output word
    always_comb begin
        row_next.row_index = row_reg;
        row_next.last_row  = (row_reg == 2'd3);
        if (near_reg) begin
            row_next.col0 = (row_reg == 2'd0) ? ONE_Q : 32'd0;
            row_next.col1 = (row_reg == 2'd1) ? ONE_Q : 32'd0;
            row_next.col2 = (row_reg == 2'd2) ? ONE_Q : 32'd0;
            row_next.col3 = (row_reg == 2'd3) ? ONE_Q : 32'd0;
        end else if (row_reg == 2'd3) begin
            row_next.col0 = tr_reg[0];
            row_next.col1 = tr_reg[1];
            row_next.col2 = tr_reg[2];
            row_next.col3 = ONE_Q;
        end else begin
            row_next.col0 = s_reg[row_reg];
            row_next.col1 = v_reg[row_reg];
            row_next.col2 = f_reg[row_reg];
            row_next.col3 = 32'd0;
        end
    end

    always_ff @(posedge clk) begin
        prod_reg <= opa * opb;
        if (!rstn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= 4'd0;
            m_valid_reg <= 1'b0;
        end else begin
            // the emit state handles the output word itself
            if (m_ready && (state_reg != ST_EMIT)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (q_valid) begin
                        eye_reg[0] <= q_item.eye_x;
                        eye_reg[1] <= q_item.eye_y;
                        eye_reg[2] <= q_item.eye_z;
                        up_reg[0]  <= q_item.up_x;
                        up_reg[1]  <= q_item.up_y;
                        up_reg[2]  <= q_item.up_z;
                        vec_reg[0] <= {{31{q_item.d_x[32]}}, q_item.d_x};
                        vec_reg[1] <= {{31{q_item.d_y[32]}}, q_item.d_y};
                        vec_reg[2] <= {{31{q_item.d_z[32]}}, q_item.d_z};
                        near_reg   <= q_item.near;
                        axis_reg   <= AX_F;
                        row_reg    <= 2'd0;
                        state_reg  <= q_item.near ? ST_EMIT : ST_MAG;
                    end
                end
                ST_MAG: begin
                    for (int i = 0; i < 3; i++) begin
                        mag_reg[i] <= vec_reg[i][63] ? 62'(-vec_reg[i]) : vec_reg[i][61:0];
                    end
                    k_reg     <= 5'd0;
                    state_reg <= ST_SHIFT;
                end
                ST_SHIFT: begin
                    // truncating shifts until every magnitude is below 2^30
                    if (big) begin
                        for (int i = 0; i < 3; i++) begin
                            mag_reg[i] <= mag_reg[i] >> 8;
                        end
                    end else if (mid) begin
                        for (int i = 0; i < 3; i++) begin
                            mag_reg[i] <= mag_reg[i] >> 1;
                        end
                    end else begin
                        cnt_reg   <= 4'd0;
                        state_reg <= ST_SQ;
                    end
                end
                ST_SQ: begin
                    if (cnt_reg != 4'd0) begin
                        s2_reg <= ((cnt_reg == 4'd1) ? 62'd0 : s2_reg)
                                  + {2'd0, prod_reg[59:0]};
                    end
                    if (cnt_reg == 4'd3) begin
                        state_reg <= ST_NORM;
                    end else begin
                        cnt_reg <= cnt_reg + 4'd1;
                    end
                end
                ST_NORM: begin
                    if (s2_reg == 62'd0) begin
                        // zero-length axis
                        for (int i = 0; i < 3; i++) begin
                            unique case (axis_reg)
                                AX_F:    f_reg[i] <= 32'sd0;
                                AX_S:    s_reg[i] <= 32'sd0;
                                default: v_reg[i] <= 32'sd0;
                            endcase
                        end
                        cnt_reg <= 4'd0;
                        unique case (axis_reg)
                            AX_F: begin
                                axis_reg  <= AX_S;
                                state_reg <= ST_CROSS;
                            end
                            AX_S: begin
                                axis_reg  <= AX_V;
                                state_reg <= ST_CROSS;
                            end
                            default: state_reg <= ST_TRANS;
                        endcase
                    end else if (s2_reg[61:52] == 10'd0) begin
                        s2_reg <= s2_reg << 8;
                        k_reg  <= k_reg + 5'd4;
                    end else if (s2_reg[61:60] == 2'd0) begin
                        s2_reg <= s2_reg << 2;
                        k_reg  <= k_reg + 5'd1;
                    end else begin
                        y_reg     <= s2_reg[61] ? GUESS_HIGH : GUESS_LOW;
                        it_reg    <= '0;
                        cnt_reg   <= 4'd0;
                        state_reg <= ST_NEWT;
                    end
                end
                ST_NEWT: begin
                    if (cnt_reg == 4'd2) begin
                        corr_reg <= (t_mid >= THREE_Q30) ? 32'd0 : THREE_Q30 - t_mid;
                    end
                    if (cnt_reg == 4'd4) begin
                        y_reg   <= (y_raw > Q30_ONE) ? Q30_ONE : y_raw;
                        cnt_reg <= 4'd0;
                        if (it_reg == IT_W'(RSQRT_ITERS - 1)) begin
                            state_reg <= ST_UNIT;
                        end else begin
                            it_reg <= it_reg + 1'b1;
                        end
                    end else begin
                        cnt_reg <= cnt_reg + 4'd1;
                    end
                end
                ST_UNIT: begin
                    if (cnt_reg != 4'd0) begin
                        unique case (axis_reg)
                            AX_F:    f_reg[cm1[1:0]] <= u_next;
                            AX_S:    s_reg[cm1[1:0]] <= u_next;
                            default: v_reg[cm1[1:0]] <= u_next;
                        endcase
                    end
                    if (cnt_reg == 4'd3) begin
                        cnt_reg <= 4'd0;
                        unique case (axis_reg)
                            AX_F: begin
                                axis_reg  <= AX_S;
                                state_reg <= ST_CROSS;
                            end
                            AX_S: begin
                                axis_reg  <= AX_V;
                                state_reg <= ST_CROSS;
                            end
                            default: state_reg <= ST_TRANS;
                        endcase
                    end else begin
                        cnt_reg <= cnt_reg + 4'd1;
                    end
                end
                ST_CROSS: begin
                    if (cnt_reg != 4'd0) begin
                        if (!cm1[0]) begin
                            acc_reg <= p64;
                        end else begin
                            vec_reg[cm1[2:1]] <= acc_reg - p64;
                        end
                    end
                    if (cnt_reg == 4'd6) begin
                        state_reg <= ST_MAG;
                    end else begin
                        cnt_reg <= cnt_reg + 4'd1;
                    end
                end
                ST_TRANS: begin
                    if (cnt_reg != 4'd0) begin
                        acc_reg <= tacc_next;
                        if (tr_lane(cm1) == 2'd2) begin
                            tr_reg[tr_axis(cm1)] <= tsat;
                        end
                    end
                    if (cnt_reg == 4'd9) begin
                        row_reg   <= 2'd0;
                        state_reg <= ST_EMIT;
                    end else begin
                        cnt_reg <= cnt_reg + 4'd1;
                    end
                end
                ST_EMIT: begin
                    if (!m_valid_reg || m_ready) begin
                        out_reg     <= row_next;
                        m_valid_reg <= 1'b1;
                        row_reg     <= row_reg + 2'd1;
                        if (row_reg == 2'd3) begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

[design/look_at_view_matrix.sv]
// Look-at view matrix. Each accepted word (eye, center, up, signed Q16.16)
// returns four row words, rows 0 to 3, the last flagged by m_last_row.
// A camera whose eye - center is within near_epsilon on every axis yields
// the identity directly. For any other camera, all products of the three
// normalizations, both cross products and the translation row run one after
// another through a single shared 33x33 multiplier, and the length of the
// shift searches before each normalization depends on magnitude. A two-word
// queue lets the input side take the next setup while the engine still
// works, and the row output is registered.
// near_epsilon sits at byte address 0; write it only while the block is idle.
module look_at_view_matrix import lavm_pkg::*; #(
    parameter int FRAC_BITS   = 16,
    parameter int RSQRT_ITERS = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_eye_x,
    input  logic [31:0] s_eye_y,
    input  logic [31:0] s_eye_z,
    input  logic [31:0] s_center_x,
    input  logic [31:0] s_center_y,
    input  logic [31:0] s_center_z,
    input  logic [31:0] s_up_x,
    input  logic [31:0] s_up_y,
    input  logic [31:0] s_up_z,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_row_index,
    output logic [31:0] m_col0,
    output logic [31:0] m_col1,
    output logic [31:0] m_col2,
    output logic [31:0] m_col3,
    output logic        m_last_row,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [15:0] eps_reg;
    logic        q_full, q_wr, q_valid, q_ready;
    item_t       wr_item, rd_item;
    row_t        row;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_NEAR_EPS) ? {16'd0, eps_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eps_reg <= 16'd1;
        end else if (psel && penable && pwrite && (paddr[2] == REG_NEAR_EPS)) begin
            eps_reg <= pwdata[15:0];
        end
    end

    lavm_front u_front (
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .eye_x    (s_eye_x),
        .eye_y    (s_eye_y),
        .eye_z    (s_eye_z),
        .center_x (s_center_x),
        .center_y (s_center_y),
        .center_z (s_center_z),
        .up_x     (s_up_x),
        .up_y     (s_up_y),
        .up_z     (s_up_z),
        .near_eps (eps_reg),
        .q_full   (q_full),
        .q_wr     (q_wr),
        .q_item   (wr_item)
    );

    lavm_queue u_queue (
        .clk      (aclk),
        .rstn     (aresetn),
        .wr_en    (q_wr),
        .wr_item  (wr_item),
        .full     (q_full),
        .rd_en    (q_ready),
        .rd_valid (q_valid),
        .rd_item  (rd_item)
    );

    lavm_engine #(
        .FRAC_BITS   (FRAC_BITS),
        .RSQRT_ITERS (RSQRT_ITERS)
    ) u_engine (
        .clk     (aclk),
        .rstn    (aresetn),
        .q_valid (q_valid),
        .q_item  (rd_item),
        .q_ready (q_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_row   (row)
    );

    assign m_row_index = row.row_index;
    assign m_col0      = row.col0;
    assign m_col1      = row.col1;
    assign m_col2      = row.col2;
    assign m_col3      = row.col3;
    assign m_last_row  = row.last_row;

endmodule

[design/lavm_checker.sv]
// port-level checks on the row output of the look-at view matrix block
// depends on assert_macros.svh; bound to look_at_view_matrix below
`include "assert_macros.svh"

module lavm_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [1:0]  m_row_index,
    input logic [31:0] m_col0,
    input logic [31:0] m_col1,
    input logic [31:0] m_col2,
    input logic [31:0] m_col3,
    input logic        m_last_row
);

    `LAVM_ASSERT(a_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_row_index) && $stable(m_col0) && $stable(m_col1) && $stable(m_col2) && $stable(m_col3) && $stable(m_last_row), "row word changed while stalled")
    `LAVM_ASSERT(a_last, aclk, aresetn, m_valid |-> (m_last_row == (m_row_index == 2'd3)), "last flag not on row 3")
    `LAVM_ASSERT(a_col3, aclk, aresetn, m_valid && !m_last_row |-> m_col3 == 32'd0, "rotation row has nonzero col3")
    `LAVM_ASSERT_ALWAYS(a_rst, aclk, !aresetn |=> !m_valid, "row word valid after reset")

endmodule

bind look_at_view_matrix lavm_checker u_lavm_checker (.*);
